[src/wslfs_pkg.sv]
package wslfs_pkg;

	localparam int NUM_W = 16;
	localparam int IDX_W = 13;

	// wheel of the six smallest primes, 2 is index 0 and 13 is index 5
	localparam int WHEEL_N = 6;
	localparam logic [2:0] WHEEL_NONE = 3'd6;

	// odd wheel primes: inverse modulo 2^16 and floor((2^16 - 1) / p)
	localparam logic [NUM_W-1:0] WHEEL_INV [WHEEL_N] = '{
		16'h0000, 16'hAAAB, 16'hCCCD, 16'h6DB7, 16'h8BA3, 16'h4EC5
	};
	localparam logic [NUM_W-1:0] WHEEL_BOUND [WHEEL_N] = '{
		16'd0, 16'd21845, 16'd13107, 16'd9362, 16'd5957, 16'd5041
	};

	// quotient bits retired per divider step
	localparam int DIV_BITS  = 2;
	localparam int DIV_STEPS = NUM_W / DIV_BITS;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	typedef enum logic [9:0] {
		ST_CLEAR = 10'b00_0000_0001,
		ST_IDLE  = 10'b00_0000_0010,
		ST_TEST  = 10'b00_0000_0100,
		ST_LOOK  = 10'b00_0000_1000,
		ST_PRD   = 10'b00_0001_0000,
		ST_DIV   = 10'b00_0010_0000,
		ST_QREAD = 10'b00_0100_0000,
		ST_LRD   = 10'b00_1000_0000,
		ST_MARK  = 10'b01_0000_0000,
		ST_DONE  = 10'b10_0000_0000
	} state_t;

	// index of the least wheel prime dividing n, WHEEL_NONE if none does;
	// odd p divides n exactly when n * inv(p) mod 2^16 is at most (2^16 - 1) / p
	function automatic logic [2:0] small_index(input logic [NUM_W-1:0] n);
		logic [2:0] r;
		logic [NUM_W-1:0] prod;
		r = WHEEL_NONE;
		for (int k = WHEEL_N - 1; k >= 1; k--) begin
			prod = NUM_W'(n * WHEEL_INV[k]);
			if (prod <= WHEEL_BOUND[k]) begin
				r = 3'(k);
			end
		end
		if (!n[0]) begin
			r = '0;
		end
		return r;
	endfunction

endpackage

[src/wheel_smallest_largest_factor_sieve.sv]
// Smallest / largest prime factor sieve over a 2-3-5-7-11-13 wheel. Feed the
// integers 2, 3, 4 ... up to sieve_limit in order, one per input beat; each
// gives one result beat. A number with a wheel factor returns
// has_small_factor with the index of that prime (2 is index 0, 13 is index 5)
// and largest_factor 0. An unmarked number off the wheel is a new prime: it
// takes the next prime index (from 6), is_prime is set, largest_factor is the
// number itself, and it marks its off-wheel multiples from its square up to
// the limit. A marked number returns the index of its smallest prime factor
// and its largest prime factor. Wheel numbers, 0, 1, numbers beyond the limit
// and a new prime that marks nothing (square beyond the limit or prime table
// full) finish after the wheel test and the number store lookup. A marked
// number also takes the quotient n / smallest factor from a divider that
// retires 2 bits a cycle, and two reads of the number store. A new prime that
// marks walks its multiples from its square upward in steps of p, one multiple
// per cycle, as the number store has a single read port. One item is in
// flight at a time; the next beat is taken while the previous result still
// waits in the output register. After reset the number store is swept clear
// before the first beat is taken; sieve_limit may be written meanwhile and
// whenever the block is idle.
module wheel_smallest_largest_factor_sieve #(
	parameter int LIMIT_MAX   = 65536,
	parameter int PRIME_SLOTS = 8192
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration: sieve_limit
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wslfs_pkg::NUM_W-1:0]   sieve_limit,
	// input beats
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [wslfs_pkg::NUM_W-1:0]   number,
	// result beats
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          has_small_factor,
	output logic                          is_prime,
	output logic [wslfs_pkg::IDX_W-1:0]   smallest_index,
	output logic [wslfs_pkg::NUM_W-1:0]   largest_factor
);

	localparam int NW = wslfs_pkg::NUM_W;
	localparam int XW = wslfs_pkg::IDX_W;
	// number store address and mark width (mark is prime index + 1, 0 = unmarked)
	localparam int AW = $clog2(LIMIT_MAX);
	localparam int MW = $clog2(PRIME_SLOTS + 1);
	localparam int PW = $clog2(PRIME_SLOTS);
	// highest number the store can hold, within the 16-bit number range
	localparam int LIM_CAP = (LIMIT_MAX - 1 > 2 ** NW - 1) ? 2 ** NW - 1 : LIMIT_MAX - 1;

	typedef struct packed {
		logic [MW-1:0] mark;
		logic [NW-1:0] lf;
	} entry_t;

	// number store: smallest-factor mark and largest factor per number
	entry_t num_mem_q [LIMIT_MAX];
	// prime table: value of each prime index handed out
	logic [NW-1:0] prime_mem_q [PRIME_SLOTS];

	wslfs_pkg::state_t state_q;

	logic [AW-1:0]   clr_q;
	logic [MW-1:0]   count_q;
	logic [NW-1:0]   sieve_limit_q;
	logic            out_valid_q;
	logic            mark_v_s1;
	logic [wslfs_pkg::DIV_CW-1:0] cnt_q;

	// payload of the item at work
	logic [NW-1:0]   n_q;
	logic [2:0]      s_q;
	logic [2*NW-1:0] sq_q;
	logic [NW:0]     m_q;
	logic [NW:0]     m_s1;
	logic            skip_s1;
	logic [MW-1:0]   mark_q;
	logic [MW-1:0]   mark_idx_q;
	logic [NW-1:0]   div_q;
	logic [NW-1:0]   rem_q;
	logic [NW-1:0]   quo_q;

	// result waiting for the output register
	logic            res_small_q;
	logic            res_prime_q;
	logic [XW-1:0]   res_idx_q;
	logic [NW-1:0]   res_lf_q;

	// output register
	logic            small_q;
	logic            prime_q;
	logic [XW-1:0]   idx_q;
	logic [NW-1:0]   lf_q;

	// memory ports
	entry_t          mem_rd_q;
	logic [NW-1:0]   prime_rd_q;
	logic            mem_we;
	logic [AW-1:0]   mem_wa;
	entry_t          mem_wd;
	logic            mem_re;
	logic [AW-1:0]   mem_ra;

	// decode
	logic [NW-1:0]   lim;
	logic            in_range;
	logic            look_small;
	logic            look_new;
	logic            room;
	logic            m_in;
	logic            mark_wr;
	logic [NW-1:0]   lrd_lf;
	logic [NW-1:0]   rem_n;
	logic [NW-1:0]   quo_n;
	logic [NW:0]     trial;
	logic            out_load;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == wslfs_pkg::ST_IDLE);

	assign out_valid        = out_valid_q;
	assign has_small_factor = small_q;
	assign is_prime         = prime_q;
	assign smallest_index   = idx_q;
	assign largest_factor   = lf_q;

	// effective limit: register clipped to what the store holds
	assign lim = (sieve_limit_q > NW'(LIM_CAP)) ? NW'(LIM_CAP) : sieve_limit_q;

	assign in_range   = (n_q >= NW'(2)) && (n_q <= lim);
	assign look_small = (s_q != wslfs_pkg::WHEEL_NONE);
	assign look_new   = !look_small && in_range && (mem_rd_q.mark == '0);
	assign room       = (count_q < MW'(PRIME_SLOTS));
	assign m_in       = (m_q <= {1'b0, lim});
	// multiple read last cycle: mark it if off the wheel and still unmarked
	assign mark_wr    = mark_v_s1 && !skip_s1 && (mem_rd_q.mark == '0);
	assign lrd_lf     = (div_q > mem_rd_q.lf) ? div_q : mem_rd_q.lf;
	assign out_load   = (state_q == wslfs_pkg::ST_DONE) && (!out_valid_q || out_ready);

	// restoring division, DIV_BITS quotient bits per step
	always_comb begin
		rem_n = rem_q;
		quo_n = quo_q;
		trial = '0;
		for (int k = 0; k < wslfs_pkg::DIV_BITS; k++) begin
			trial = {rem_n, quo_n[NW-1]};
			quo_n = {quo_n[NW-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_n    = NW'(trial - {1'b0, div_q});
				quo_n[0] = 1'b1;
			end else begin
				rem_n = trial[NW-1:0];
			end
		end
	end

	// number store port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = AW'(n_q);
		mem_wd = '0;
		mem_re = 1'b0;
		mem_ra = AW'(n_q);
		case (state_q)
			wslfs_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
			end
			wslfs_pkg::ST_TEST: begin
				mem_re = 1'b1;
			end
			wslfs_pkg::ST_LOOK: begin
				// new prime: its own mark (if a slot is left) and largest factor
				mem_we      = look_new;
				mem_wd.mark = room ? MW'(count_q + MW'(1)) : mem_rd_q.mark;
				mem_wd.lf   = n_q;
			end
			wslfs_pkg::ST_MARK: begin
				mem_re      = m_in;
				mem_ra      = AW'(m_q);
				mem_we      = mark_wr;
				mem_wa      = AW'(m_s1);
				mem_wd.mark = mark_idx_q;
				mem_wd.lf   = mem_rd_q.lf;
			end
			wslfs_pkg::ST_QREAD: begin
				mem_re = 1'b1;
				mem_ra = AW'(quo_q);
			end
			wslfs_pkg::ST_LRD: begin
				mem_we      = 1'b1;
				mem_wd.mark = mark_q;
				mem_wd.lf   = lrd_lf;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			num_mem_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_q <= num_mem_q[mem_ra];
		end
	end

	// prime table: append on a new prime, look up a marked number's factor
	always_ff @(posedge clk) begin
		if (state_q == wslfs_pkg::ST_LOOK) begin
			if (look_new && room) begin
				prime_mem_q[PW'(count_q)] <= n_q;
			end
			prime_rd_q <= prime_mem_q[PW'(mem_rd_q.mark - MW'(1))];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= wslfs_pkg::ST_CLEAR;
			clr_q         <= '0;
			count_q       <= MW'(wslfs_pkg::WHEEL_N);
			sieve_limit_q <= '1;
			out_valid_q   <= 1'b0;
			mark_v_s1     <= 1'b0;
			cnt_q         <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				sieve_limit_q <= sieve_limit;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			mark_v_s1 <= (state_q == wslfs_pkg::ST_MARK) && m_in;
			case (state_q)
				wslfs_pkg::ST_CLEAR: begin
					clr_q <= AW'(clr_q + AW'(1));
					if (clr_q == AW'(LIMIT_MAX - 1)) begin
						state_q <= wslfs_pkg::ST_IDLE;
					end
				end
				wslfs_pkg::ST_IDLE: begin
					if (in_valid) begin
						state_q <= wslfs_pkg::ST_TEST;
					end
				end
				wslfs_pkg::ST_TEST: begin
					state_q <= wslfs_pkg::ST_LOOK;
				end
				wslfs_pkg::ST_LOOK: begin
					if (look_small || !in_range) begin
						state_q <= wslfs_pkg::ST_DONE;
					end else if (look_new) begin
						if (room) begin
							count_q <= MW'(count_q + MW'(1));
						end
						if (room && (sq_q <= {{NW{1'b0}}, lim})) begin
							state_q <= wslfs_pkg::ST_MARK;
						end else begin
							state_q <= wslfs_pkg::ST_DONE;
						end
					end else begin
						state_q <= wslfs_pkg::ST_PRD;
					end
				end
				wslfs_pkg::ST_PRD: begin
					cnt_q   <= '0;
					state_q <= wslfs_pkg::ST_DIV;
				end
				wslfs_pkg::ST_DIV: begin
					cnt_q <= wslfs_pkg::DIV_CW'(cnt_q + 1'b1);
					if (cnt_q == wslfs_pkg::DIV_CW'(wslfs_pkg::DIV_STEPS - 1)) begin
						state_q <= wslfs_pkg::ST_QREAD;
					end
				end
				wslfs_pkg::ST_QREAD: begin
					state_q <= wslfs_pkg::ST_LRD;
				end
				wslfs_pkg::ST_LRD: begin
					state_q <= wslfs_pkg::ST_DONE;
				end
				wslfs_pkg::ST_MARK: begin
					// last multiple's write lands this cycle
					if (!m_in) begin
						state_q <= wslfs_pkg::ST_DONE;
					end
				end
				wslfs_pkg::ST_DONE: begin
					if (out_load) begin
						state_q <= wslfs_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= wslfs_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			wslfs_pkg::ST_IDLE: begin
				n_q <= number;
			end
			wslfs_pkg::ST_TEST: begin
				s_q  <= wslfs_pkg::small_index(n_q);
				sq_q <= n_q * n_q;
			end
			wslfs_pkg::ST_LOOK: begin
				res_small_q <= 1'b0;
				res_prime_q <= 1'b0;
				res_idx_q   <= '0;
				res_lf_q    <= '0;
				if (look_small) begin
					res_small_q <= 1'b1;
					res_idx_q   <= XW'(s_q);
				end else if (look_new) begin
					res_prime_q <= 1'b1;
					res_lf_q    <= n_q;
					res_idx_q   <= room ? XW'(count_q) : '0;
					mark_idx_q  <= MW'(count_q + MW'(1));
					m_q         <= (NW + 1)'(sq_q);
				end else if (in_range) begin
					mark_q    <= mem_rd_q.mark;
					res_idx_q <= XW'(mem_rd_q.mark - MW'(1));
				end
			end
			wslfs_pkg::ST_PRD: begin
				div_q <= prime_rd_q;
				rem_q <= '0;
				quo_q <= n_q;
			end
			wslfs_pkg::ST_DIV: begin
				rem_q <= rem_n;
				quo_q <= quo_n;
			end
			wslfs_pkg::ST_LRD: begin
				res_lf_q <= lrd_lf;
			end
			wslfs_pkg::ST_MARK: begin
				m_q     <= (NW + 1)'(m_q + (NW + 1)'(n_q));
				m_s1    <= m_q;
				skip_s1 <= (wslfs_pkg::small_index(m_q[NW-1:0]) != wslfs_pkg::WHEEL_NONE);
			end
			default: begin
			end
		endcase
		if (out_load) begin
			small_q <= res_small_q;
			prime_q <= res_prime_q;
			idx_q   <= res_idx_q;
			lf_q    <= res_lf_q;
		end
	end

	// a multiple being marked always lies above the prime that marks it
	assert property (@(posedge clk) disable iff (!arst_n)
		mark_wr |-> (m_s1 > {1'b0, n_q}))
		else $error("marking write at or below the current prime");

	// a wheel number is never a new prime and carries no largest factor
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && has_small_factor) |-> (!is_prime && (largest_factor == '0)))
		else $error("small-divisible result with prime flag or largest factor");

	// no input beat is taken while an item is still in the marking loop
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wslfs_pkg::ST_MARK) |-> !in_ready)
		else $error("input taken during marking");

	// the output register only loads from a finished item
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !$past(out_valid)) |-> $past(state_q == wslfs_pkg::ST_DONE))
		else $error("result shown without a finished item");

endmodule
